>>> design/cpu_load_window_monitor_unit_assert.svh
// Assertion macros used by the checker file clwm_checker.sv.
`ifndef CPU_LOAD_WINDOW_MONITOR_UNIT_ASSERT_SVH
`define CPU_LOAD_WINDOW_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CLWM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CLWM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/clwm_pkg.sv
package clwm_pkg;

    localparam int OP_W       = 2;
    localparam int TIMER_W    = 32;
    localparam int TOTAL_W    = 64;
    localparam int LOAD_W     = 15;
    localparam int DEPTH_W    = 8;
    localparam int QUO_W      = 15;
    localparam int NUM_W      = TIMER_W + QUO_W;
    localparam int CNT_W      = 4;
    localparam int MAX_NEST_DEF = 255;

    localparam logic [LOAD_W-1:0]  FULL_LOAD    = 15'd25600;
    localparam logic [TIMER_W-1:0] WINDOW_RESET = 32'd100000000;

    typedef enum logic [OP_W-1:0] {
        OP_ENTRY = 2'd0,
        OP_EXIT  = 2'd1,
        OP_BEGIN = 2'd2,
        OP_END   = 2'd3
    } op_t;

endpackage

>>> design/clwm_in_if.sv
interface clwm_in_if
    import clwm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      opcode;
    logic [TIMER_W-1:0]   timer_now;
    logic [TOTAL_W-1:0]   idle_total;

    modport source (output valid, output opcode, output timer_now, output idle_total,
                    input ready);
    modport sink   (input valid, input opcode, input timer_now, input idle_total,
                    output ready);
endinterface

>>> design/clwm_out_if.sv
interface clwm_out_if
    import clwm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [LOAD_W-1:0]    load_fixed;
    logic                 load_valid;
    logic [DEPTH_W-1:0]   nest_depth;
    logic                 nest_error;

    modport source (output valid, output load_fixed, output load_valid,
                    output nest_depth, output nest_error, input ready);
    modport sink   (input valid, input load_fixed, input load_valid,
                    input nest_depth, input nest_error, output ready);
endinterface

>>> design/cpu_load_window_monitor_unit.sv
// CPU load monitor: takes one event word at a time (interrupt entry, interrupt exit,
// window begin, window end) and returns one result word per event. The outermost exit
// adds its span to the interrupt total. Adds and subtracts on times and totals run
// through one shared 65-bit add/subtract unit stepped by a small sequencer; the
// multiply by full load is separate. Window end runs a 15-step restoring division of
// the rounded load numerator by the window register on that unit. in_ch.ready is high
// only while the sequencer is idle; a finished result waits in the output register
// without holding up the next event, though the next result waits in S_EMIT until taken.
module cpu_load_window_monitor_unit
    import clwm_pkg::*;
#(
    parameter int MAX_NEST = MAX_NEST_DEF
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [TIMER_W-1:0]  cfg_wr_data,
    clwm_in_if.sink             in_ch,
    clwm_out_if.source          out_ch
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_EXEC = 10'b00_0000_0010,
        S_ACC  = 10'b00_0000_0100,
        S_IDEL = 10'b00_0000_1000,
        S_REAL = 10'b00_0001_0000,
        S_CHK  = 10'b00_0010_0000,
        S_MUL  = 10'b00_0100_0000,
        S_RND  = 10'b00_1000_0000,
        S_DIV  = 10'b01_0000_0000,
        S_EMIT = 10'b10_0000_0000
    } state_t;

    state_t               state_reg, state_next;

    logic [TIMER_W-1:0]   window_reg;
    op_t                  op_reg;
    logic [TIMER_W-1:0]   now_reg;
    logic [TOTAL_W-1:0]   idle_reg;

    logic [DEPTH_W-1:0]   nest_reg, nest_next;
    logic [TIMER_W-1:0]   stamp_reg, stamp_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [TOTAL_W-1:0]   int_base_reg, int_base_next;
    logic [TOTAL_W-1:0]   idle_base_reg, idle_base_next;

    logic [TOTAL_W-1:0]   acc_reg, acc_next;
    logic [TOTAL_W-1:0]   tmp_reg, tmp_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [TIMER_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic [LOAD_W-1:0]    res_load_reg, res_load_next;
    logic                 res_err_reg, res_err_next;

    logic                 out_valid_reg;
    logic [LOAD_W-1:0]    out_load_reg;
    logic                 out_lvalid_reg;
    logic [DEPTH_W-1:0]   out_depth_reg;
    logic                 out_err_reg;

    logic [TOTAL_W-1:0]   alu_a, alu_b;
    logic                 alu_sub;
    logic [TOTAL_W:0]     alu_sum;
    logic                 alu_carry;
    logic                 accept;
    logic                 emit;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign emit = (state_reg == S_EMIT) && (!out_valid_reg || out_ch.ready);

    // Shared add/subtract unit; carry out set means a >= b on subtract
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (state_reg)
            S_EXEC:
            begin
                if (op_reg == OP_EXIT)
                begin
                    alu_a = {32'd0, now_reg};
                    alu_b = {32'd0, stamp_reg};
                end
                else
                begin
                    alu_a = idle_reg;
                    alu_b = idle_base_reg;
                end
            end
            S_ACC:
            begin
                alu_a   = total_reg;
                alu_b   = {32'd0, tmp_reg[TIMER_W-1:0]};
                alu_sub = 1'b0;
            end
            S_IDEL:
            begin
                alu_a = total_reg;
                alu_b = int_base_reg;
            end
            S_REAL:
            begin
                alu_a = acc_reg;
                alu_b = tmp_reg;
            end
            S_CHK:
            begin
                alu_a = {32'd0, window_reg};
                alu_b = acc_reg;
            end
            S_RND:
            begin
                alu_a   = {{(TOTAL_W-NUM_W){1'b0}}, num_reg};
                alu_b   = {33'd0, window_reg[TIMER_W-1:1]};
                alu_sub = 1'b0;
            end
            S_DIV:
            begin
                alu_a = {31'd0, rem_reg, num_reg[QUO_W-1]};
                alu_b = {32'd0, window_reg};
            end
            default:
            begin
                alu_sub = 1'b1;
            end
        endcase
    end

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + {{TOTAL_W{1'b0}}, alu_sub};
    assign alu_carry = alu_sum[TOTAL_W];

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        nest_next      = nest_reg;
        stamp_next     = stamp_reg;
        total_next     = total_reg;
        int_base_next  = int_base_reg;
        idle_base_next = idle_base_reg;
        acc_next       = acc_reg;
        tmp_next       = tmp_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        res_load_next  = res_load_reg;
        res_err_next   = res_err_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_load_next = '0;
                    res_err_next  = 1'b0;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_EMIT;
                case (op_reg)
                    OP_ENTRY:
                    begin
                        if (nest_reg >= DEPTH_W'(MAX_NEST))
                        begin
                            res_err_next = 1'b1;
                        end
                        else
                        begin
                            if (nest_reg == '0)
                            begin
                                stamp_next = now_reg;
                            end
                            nest_next = nest_reg + 1'b1;
                        end
                    end
                    OP_EXIT:
                    begin
                        if (nest_reg == '0)
                        begin
                            res_err_next = 1'b1;
                        end
                        else
                        begin
                            nest_next = nest_reg - 1'b1;
                            if (nest_reg == DEPTH_W'(1))
                            begin
                                tmp_next   = {32'd0, alu_sum[TIMER_W-1:0]};
                                state_next = S_ACC;
                            end
                        end
                    end
                    OP_BEGIN:
                    begin
                        int_base_next  = total_reg;
                        idle_base_next = idle_reg;
                    end
                    OP_END:
                    begin
                        acc_next   = alu_sum[TOTAL_W-1:0];
                        state_next = S_IDEL;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_ACC:
            begin
                total_next = alu_sum[TOTAL_W-1:0];
                state_next = S_EMIT;
            end
            S_IDEL:
            begin
                tmp_next   = alu_sum[TOTAL_W-1:0];
                state_next = S_REAL;
            end
            S_REAL:
            begin
                // floor real idle at zero
                acc_next   = alu_carry ? alu_sum[TOTAL_W-1:0] : '0;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // idle at or above the window, or a zero window, gives zero load
                if (!alu_carry || (alu_sum[TOTAL_W-1:0] == '0))
                begin
                    res_load_next = '0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    tmp_next   = {32'd0, alu_sum[TIMER_W-1:0]};
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                num_next   = NUM_W'(tmp_reg[TIMER_W-1:0]) * NUM_W'(FULL_LOAD);
                state_next = S_RND;
            end
            S_RND:
            begin
                // add half the window for round half up; high part seeds the remainder
                num_next   = alu_sum[NUM_W-1:0];
                rem_next   = alu_sum[NUM_W-1:QUO_W];
                quo_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = alu_carry ? alu_sum[TIMER_W-1:0]
                                     : {rem_reg[TIMER_W-2:0], num_reg[QUO_W-1]};
                quo_next = {quo_reg[QUO_W-2:0], alu_carry};
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    if ({quo_reg[QUO_W-2:0], alu_carry} > FULL_LOAD)
                    begin
                        res_load_next = FULL_LOAD;
                    end
                    else
                    begin
                        res_load_next = {quo_reg[QUO_W-2:0], alu_carry};
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WINDOW_RESET;
            nest_reg      <= '0;
            stamp_reg     <= '0;
            total_reg     <= '0;
            int_base_reg  <= '0;
            idle_base_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nest_reg      <= nest_next;
            stamp_reg     <= stamp_next;
            total_reg     <= total_next;
            int_base_reg  <= int_base_next;
            idle_base_reg <= idle_base_next;
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(in_ch.opcode);
            now_reg  <= in_ch.timer_now;
            idle_reg <= in_ch.idle_total;
        end
        acc_reg      <= acc_next;
        tmp_reg      <= tmp_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        res_load_reg <= res_load_next;
        res_err_reg  <= res_err_next;
        if (emit)
        begin
            out_load_reg   <= res_load_reg;
            out_lvalid_reg <= (op_reg == OP_END);
            out_depth_reg  <= nest_reg;
            out_err_reg    <= res_err_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.load_fixed = out_load_reg;
    assign out_ch.load_valid = out_lvalid_reg;
    assign out_ch.nest_depth = out_depth_reg;
    assign out_ch.nest_error = out_err_reg;

endmodule

>>> design/clwm_checker.sv
`include "cpu_load_window_monitor_unit_assert.svh"

module clwm_checker
    import clwm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [LOAD_W-1:0]   load_fixed,
    input  logic                load_valid,
    input  logic [DEPTH_W-1:0]  nest_depth,
    input  logic                nest_error
);

    // a stalled result word stays valid and holds its load, depth and error fields
    `CLWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(load_fixed) && $stable(nest_depth) && $stable(nest_error),
        "result word changed while stalled")

    // one event at a time: the sequencer drops ready after an accept
    `CLWM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "ready stayed high after an accepted word")

    // load is only carried on window end and never exceeds full load
    `CLWM_ASSERT_NOW(a_load_range, out_valid,
        (load_fixed <= FULL_LOAD) && (load_valid || (load_fixed == '0)),
        "load value out of range or present without window end")

    // window end never flags a nesting error
    `CLWM_ASSERT_NOW(a_end_no_err, out_valid && load_valid, !nest_error,
        "nesting error on window end")

endmodule

bind cpu_load_window_monitor_unit clwm_checker u_clwm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .load_fixed (out_ch.load_fixed),
    .load_valid (out_ch.load_valid),
    .nest_depth (out_ch.nest_depth),
    .nest_error (out_ch.nest_error)
);

>>> test/load_window_checker.sv
module load_window_checker
    import clwm_pkg::*;
#(
    parameter int MAX_NEST = MAX_NEST_DEF
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [TIMER_W-1:0]  cfg_wr_data,
    clwm_in_if                  in_ch,
    clwm_out_if                 out_ch,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [LOAD_W-1:0]  load_fixed;
        logic               load_valid;
        logic [DEPTH_W-1:0] nest_depth;
        logic               nest_error;
    } load_report_t;

    // Shadow copy of the monitor state and its window register
    logic [TIMER_W-1:0] window_ticks;
    logic [DEPTH_W-1:0] depth;
    logic [TIMER_W-1:0] entry_stamp;
    logic [TOTAL_W-1:0] irq_total;
    logic [TOTAL_W-1:0] irq_base;
    logic [TOTAL_W-1:0] idle_base;

    load_report_t expected_reports[$];

    // Load percent times 256 over the current window, round half up
    function automatic logic [LOAD_W-1:0] window_load(input logic [TOTAL_W-1:0] idle_now);
        logic [TOTAL_W-1:0] idle_delta;
        logic [TOTAL_W-1:0] irq_delta;
        logic [TOTAL_W-1:0] real_idle;
        logic [TOTAL_W-1:0] w;
        logic [TOTAL_W-1:0] num;
        idle_delta = idle_now - idle_base;
        irq_delta  = irq_total - irq_base;
        real_idle  = (idle_delta > irq_delta) ? idle_delta - irq_delta : '0;
        w = TOTAL_W'(window_ticks);
        // A zero window counts as endless idle
        if (w == 0 || real_idle >= w)
            return '0;
        num = (TOTAL_W'(FULL_LOAD) * (w - real_idle) + (w >> 1)) / w;
        if (num > TOTAL_W'(FULL_LOAD))
            num = TOTAL_W'(FULL_LOAD);
        return num[LOAD_W-1:0];
    endfunction

    // Advance the shadow state by one event word and return its report
    function automatic load_report_t apply_event(input op_t op,
                                                 input logic [TIMER_W-1:0] now,
                                                 input logic [TOTAL_W-1:0] idle_now);
        load_report_t rep;
        logic [TIMER_W-1:0] span;
        rep = '0;
        case (op)
            OP_ENTRY:
            begin
                // Saturate at the deepest nesting level
                if (depth >= MAX_NEST)
                    rep.nest_error = 1'b1;
                else
                begin
                    if (depth == 0)
                        entry_stamp = now;
                    depth = depth + 1'b1;
                end
            end
            OP_EXIT:
            begin
                if (depth == 0)
                    rep.nest_error = 1'b1;
                else
                begin
                    depth = depth - 1'b1;
                    if (depth == 0)
                    begin
                        span = now - entry_stamp;
                        irq_total = irq_total + TOTAL_W'(span);
                    end
                end
            end
            OP_BEGIN:
            begin
                irq_base  = irq_total;
                idle_base = idle_now;
            end
            default:
            begin
                rep.load_fixed = window_load(idle_now);
                rep.load_valid = 1'b1;
            end
        endcase
        rep.nest_depth = depth;
        return rep;
    endfunction

    function automatic int field_differs(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Predict on every accepted event word, compare on every accepted result word
    always @(posedge clk)
    begin
        load_report_t want;
        int bad;
        bad = 0;
        if (!rst_n)
        begin
            window_ticks = WINDOW_RESET;
            depth        = '0;
            entry_stamp  = '0;
            irq_total    = '0;
            irq_base     = '0;
            idle_base    = '0;
            expected_reports.delete();
        end
        else
        begin
            if (cfg_wr_en)
                window_ticks = cfg_wr_data;
            if (in_ch.valid && in_ch.ready)
                expected_reports.push_back(apply_event(op_t'(in_ch.opcode), in_ch.timer_now,
                                                       in_ch.idle_total));
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result word with no event waiting: load_fixed %0d nest_depth %0d",
                           out_ch.load_fixed, out_ch.nest_depth);
                    bad++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    bad += field_differs("load_fixed", want.load_fixed, out_ch.load_fixed);
                    bad += field_differs("load_valid", want.load_valid, out_ch.load_valid);
                    bad += field_differs("nest_depth", want.nest_depth, out_ch.nest_depth);
                    bad += field_differs("nest_error", want.nest_error, out_ch.nest_error);
                end
            end
        end
        pending    <= expected_reports.size();
        fail_count <= fail_count + bad;
    end

endmodule

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import clwm_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en;
    logic [TIMER_W-1:0] cfg_wr_data;

    clwm_in_if  in_ch();
    clwm_out_if out_ch();

    int fail_count;
    int pending;

    // Stimulus bookkeeping
    int                 words_sent;
    int                 burst_left;
    int                 open_irq;
    logic [TIMER_W-1:0] clk_stamp;
    logic [TOTAL_W-1:0] idle_acc;
    logic [TIMER_W-1:0] window_now;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    cpu_load_window_monitor_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    load_window_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    function automatic logic [63:0] rand_word64();
        return {$urandom, $urandom};
    endfunction

    // Offer one event word; open a random gap between bursts
    task automatic send_event(input op_t op, input logic [TIMER_W-1:0] stamp,
                              input logic [TOTAL_W-1:0] idle);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 28);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.timer_now  <= stamp;
        in_ch.idle_total <= idle;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
        words_sent++;
        if (op == OP_ENTRY && open_irq < MAX_NEST_DEF)
            open_irq++;
        else if (op == OP_EXIT && open_irq > 0)
            open_irq--;
    endtask

    // Hold the sender until every result word is back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_window(input logic [TIMER_W-1:0] ticks);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        window_now = ticks;
    endtask

    task automatic clock_ahead();
        clk_stamp = clk_stamp + $urandom_range(1, 3000);
        idle_acc  = idle_acc + $urandom_range(0, 3000);
    endtask

    // One well-formed window: exits for open interrupts, begin, up to four interrupt spans, one or two ends
    task automatic run_window();
        logic [TOTAL_W-1:0] scale;
        logic [TOTAL_W-1:0] irq_sum;
        logic [TOTAL_W-1:0] base;
        logic [TOTAL_W-1:0] extra;
        logic [TOTAL_W-1:0] idle;
        logic [TIMER_W-1:0] outer;
        logic [TIMER_W-1:0] span;
        int nest;
        scale = (window_now == 0) ? 64'd1000 : TOTAL_W'(window_now);
        while (open_irq > 0)
        begin
            clock_ahead();
            send_event(OP_EXIT, clk_stamp, idle_acc);
        end
        clock_ahead();
        base    = idle_acc;
        irq_sum = '0;
        send_event(OP_BEGIN, clk_stamp, base);
        repeat ($urandom_range(0, 4))
        begin
            clock_ahead();
            outer = clk_stamp;
            span  = TIMER_W'(rand_word64() % (scale / 8 + 1));
            nest  = $urandom_range(1, 3);
            send_event(OP_ENTRY, outer, idle_acc);
            repeat (nest - 1)
                send_event(OP_ENTRY, outer + TIMER_W'($urandom % (span + 64'd1)), idle_acc);
            repeat (nest - 1)
                send_event(OP_EXIT, outer + TIMER_W'($urandom % (span + 64'd1)), idle_acc);
            send_event(OP_EXIT, outer + span, idle_acc);
            clk_stamp = outer + span;
            irq_sum   = irq_sum + TOTAL_W'(span);
        end
        repeat ($urandom_range(1, 2))
        begin
            clock_ahead();
            case ($urandom_range(0, 5))
                0: extra = '0;
                1: extra = scale;
                2, 3: extra = rand_word64() % (scale + 1);
                default: extra = ($urandom_range(0, 1) != 0) ? scale - 1 : 64'd1;
            endcase
            idle = base + irq_sum + extra;
            // Idle below the interrupt time floors at zero
            if ($urandom_range(0, 5) == 0)
                idle = base + rand_word64() % (irq_sum + 1);
            send_event(OP_END, clk_stamp, idle);
            idle_acc = idle;
        end
    endtask

    // Random or broken words: unbalanced exits and entries, stray ends
    task automatic send_stray();
        case ($urandom_range(0, 3))
            0: send_event(op_t'($urandom_range(0, 3)), $urandom, rand_word64());
            1: repeat ($urandom_range(1, 3)) send_event(OP_ENTRY, $urandom, rand_word64());
            2: repeat ($urandom_range(1, 3)) send_event(OP_EXIT, $urandom, rand_word64());
            default: send_event(OP_END, $urandom, idle_acc + rand_word64() % 64'd200000);
        endcase
    endtask

    // Nest to the limit, overrun it, unwind and underrun
    task automatic run_nest_storm();
        while (open_irq < MAX_NEST_DEF)
        begin
            clock_ahead();
            send_event(OP_ENTRY, clk_stamp, idle_acc);
        end
        repeat (3) send_event(OP_ENTRY, $urandom, rand_word64());
        while (open_irq > 0)
        begin
            clock_ahead();
            send_event(OP_EXIT, clk_stamp, idle_acc);
        end
        repeat (2) send_event(OP_EXIT, $urandom, rand_word64());
    endtask

    // Result side: stall on changing patterns, one long hold-off
    initial
    begin
        int pct;
        int mode_left;
        bit held;
        out_ch.ready <= 1'b0;
        pct = 100;
        mode_left = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && words_sent >= 150)
            begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 3))
                        0: pct = 100;
                        1: pct = 80;
                        2: pct = 50;
                        default: pct = 15;
                    endcase
                end
                mode_left--;
                out_ch.ready <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [TIMER_W-1:0] plan [7];
        int phase_end;
        int sel;
        bit stormed;
        plan = '{32'd1000, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd2048, 32'd0, 32'd65536};
        plan[5] = $urandom_range(1, 32'h00FF_FFFF);
        in_ch.valid      <= 1'b0;
        in_ch.opcode     <= OP_ENTRY;
        in_ch.timer_now  <= '0;
        in_ch.idle_total <= '0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        words_sent = 0;
        burst_left = 0;
        open_irq   = 0;
        stormed    = 1'b0;
        window_now = WINDOW_RESET;
        clk_stamp  = $urandom;
        idle_acc   = rand_word64();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset window
        send_event(OP_END, 32'd0, 64'd0);
        send_event(OP_EXIT, 32'd5, 64'd0);
        send_event(OP_ENTRY, 32'hFFFF_FFF0, 64'd0);
        send_event(OP_ENTRY, 32'hFFFF_FFF8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_event(OP_EXIT, 32'h0000_0004, 64'd0);
        send_event(OP_EXIT, 32'h0000_0010, 64'd0);
        send_event(OP_BEGIN, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00);
        send_event(OP_END, 32'd0, 64'd1000);
        send_event(OP_END, 32'd0, 64'd100000000);
        send_event(OP_END, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);

        // Directed words at a small even window: floor, half-up, edges
        set_window(32'd2048);
        send_event(OP_BEGIN, 32'd0, 64'd0);
        send_event(OP_ENTRY, 32'd100, 64'd0);
        send_event(OP_EXIT, 32'd5100, 64'd0);
        send_event(OP_END, 32'd5200, 64'd100);
        send_event(OP_END, 32'd5200, 64'd5001);
        send_event(OP_END, 32'd5200, 64'd7047);
        send_event(OP_END, 32'd5200, 64'd7048);

        // Random phases, one window setting each
        for (int p = 0; p < 7; p++)
        begin
            set_window(plan[p]);
            phase_end = words_sent + 45;
            while (words_sent < phase_end)
            begin
                sel = $urandom_range(0, 99);
                if (p == 1 && !stormed)
                begin
                    stormed = 1'b1;
                    run_nest_storm();
                end
                else if (sel < 75)
                    run_window();
                else
                    send_stray();
            end
        end

        drain_results();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
